// ===== design/tpl_pkg.sv =====
// Package for the triangle point location unit: sizes, field widths and
// the word that passes from the front part to the back part through the queue.
// No dependencies.
package tpl_pkg;
  localparam int MaxTriangles = 64;
  localparam int CoordBits = 24;
  localparam int IdxBits = $clog2(MaxTriangles);
  localparam int CntBits = 7;
  localparam int TolBits = 16;
  localparam int WeightBits = 18;
  localparam int DiffBits = CoordBits + 1;
  localparam int CrossBits = 2 * DiffBits + 1;
  localparam int QuotBits = 22;
  localparam int QueueDepth = 2;
  localparam int StoreBits = 6 * CoordBits;

  localparam logic ModeWrite = 1'b0;
  localparam logic ModeQuery = 1'b1;

  localparam logic RegTriangleCount = 1'b0;
  localparam logic RegEdgeTolerance = 1'b1;

  typedef struct packed {
    logic [IdxBits-1:0] entry_index;
    logic signed [CoordBits-1:0] ax;
    logic signed [CoordBits-1:0] ay;
    logic signed [CoordBits-1:0] bx;
    logic signed [CoordBits-1:0] by;
    logic signed [CoordBits-1:0] cx;
    logic signed [CoordBits-1:0] cy;
    logic signed [CoordBits-1:0] px;
    logic signed [CoordBits-1:0] py;
    logic mode;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_CROSS, ST_MUL, ST_DIV, ST_TEST, ST_OUT
  } state_t;
endpackage

// ===== design/triangle_point_location_unit.sv =====
// Triangle point location unit: write words load one of 64 triangle entries;
// query words scan entries 0..count-1 (count capped at 64) and return the first containing one.
// A write is stored as it leaves the queue, which it does only while the back part is idle.
// A query leaves the queue, passes ST_READ, ST_CROSS and ST_MUL for each entry, plus ST_DIV
// (bit-serial weight divider) and ST_TEST for a non-degenerate one; ST_OUT raises out_valid.
// One query is in the back part at a time; a two-word queue decouples the input.
// Reset (rst, synchronous) clears control and count, sets tolerance 66; the table is undefined.
module triangle_point_location_unit (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_index,
  input  logic [15:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic mode,
  input  logic [5:0] entry_index,
  input  logic signed [23:0] corner_a_x,
  input  logic signed [23:0] corner_a_y,
  input  logic signed [23:0] corner_b_x,
  input  logic signed [23:0] corner_b_y,
  input  logic signed [23:0] corner_c_x,
  input  logic signed [23:0] corner_c_y,
  input  logic signed [23:0] point_x,
  input  logic signed [23:0] point_y,
  output logic out_valid,
  input  logic out_ready,
  output logic found,
  output logic [5:0] triangle_index,
  output logic signed [17:0] weight_a,
  output logic signed [17:0] weight_b,
  output logic signed [17:0] weight_c
);
  // Configuration registers; writes are always taken.
  logic [tpl_pkg::CntBits-1:0] triangle_count;
  logic [tpl_pkg::TolBits-1:0] edge_tolerance;
  tpl_pkg::cmd_t in_cmd;
  tpl_pkg::cmd_t q_cmd;
  logic q_valid;
  logic q_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      triangle_count <= '0;
      edge_tolerance <= tpl_pkg::TolBits'(66);
    end else if (cfg_valid) begin
      if (cfg_index == tpl_pkg::RegTriangleCount) begin
        triangle_count <= cfg_data[tpl_pkg::CntBits-1:0];
      end else begin
        edge_tolerance <= cfg_data;
      end
    end
  end

  // Bundle the input word for the queue.
  always_comb begin
    in_cmd.mode        = mode;
    in_cmd.entry_index = entry_index;
    in_cmd.ax = corner_a_x;
    in_cmd.ay = corner_a_y;
    in_cmd.bx = corner_b_x;
    in_cmd.by = corner_b_y;
    in_cmd.cx = corner_c_x;
    in_cmd.cy = corner_c_y;
    in_cmd.px = point_x;
    in_cmd.py = point_y;
  end

  tpl_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  tpl_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .triangle_count(triangle_count), .edge_tolerance(edge_tolerance),
    .out_valid(out_valid), .out_ready(out_ready), .found(found),
    .triangle_index(triangle_index), .weight_a(weight_a),
    .weight_b(weight_b), .weight_c(weight_c)
  );
endmodule

// ===== design/tpl_ram.sv =====
// Generic single-port-write, single-read RAM with a registered read port.
// No dependencies.
module tpl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/tpl_front.sv =====
// Front part: accepts input words and holds them in a short queue.
// Depends on tpl_pkg.
module tpl_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  tpl_pkg::cmd_t in_cmd,
  output logic          q_valid,
  input  logic          q_ready,
  output tpl_pkg::cmd_t q_cmd
);
  localparam int PtrBits = $clog2(tpl_pkg::QueueDepth);

  tpl_pkg::cmd_t slots [tpl_pkg::QueueDepth];
  logic [PtrBits-1:0] wr_ptr;
  logic [PtrBits-1:0] rd_ptr;
  logic [PtrBits:0]   fill;
  logic push;
  logic pop;

  assign in_ready = (fill != PtrBits'(0) + (PtrBits+1)'(tpl_pkg::QueueDepth));
  assign q_valid  = (fill != '0);
  assign q_cmd    = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PtrBits'(1);
      if (pop)  rd_ptr <= rd_ptr + PtrBits'(1);
      fill <= fill + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
    end
  end

`ifndef ASSERT_OFF
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= (PtrBits+1)'(tpl_pkg::QueueDepth))
    else $error("queue overfilled");
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> fill == $past(fill) + 1'b1)
    else $error("queue count lost a push");
  a_empty_no_pop: assert property (@(posedge clk) disable iff (rst)
    fill == '0 |-> !q_valid)
    else $error("empty queue presented a word");
`endif
endmodule

// ===== design/tpl_div.sv =====
// Restoring divider: floor(num * 65536 / den) for den > 0, saturated to
// +-2^20, one quotient bit per cycle. Depends on tpl_pkg.
module tpl_div (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  input  logic signed [tpl_pkg::CrossBits-1:0]     num,
  input  logic [tpl_pkg::CrossBits-1:0]            den,
  output logic                                     done,
  output logic signed [tpl_pkg::QuotBits-1:0]      quo
);
  localparam int RemBits = tpl_pkg::CrossBits + 17;
  localparam int DenBits = tpl_pkg::CrossBits + 21;

  logic [RemBits-1:0] rem;
  logic [DenBits-1:0] dsh;
  logic [19:0] q;
  logic [4:0]  bit_cnt;
  logic        busy;
  logic        neg;
  logic        sat;
  logic [tpl_pkg::CrossBits-1:0] mag;
  logic [DenBits-1:0] trial;
  logic [DenBits-1:0] rem_ext;
  logic [19:0] qf;

  assign mag     = num[tpl_pkg::CrossBits-1] ? -num : num;
  assign trial   = dsh >> bit_cnt;
  assign rem_ext = DenBits'(rem);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        neg     <= num[tpl_pkg::CrossBits-1];
        rem     <= {mag, 16'b0} + RemBits'(0);
        dsh     <= {DenBits'(den)} << 19;
        sat     <= ({4'b0, mag, 16'b0} >= ({DenBits'(den)} << 20));
        q       <= '0;
        bit_cnt <= '0;
      end else if (busy) begin
        if (!sat && rem_ext >= trial) begin
          rem <= rem - RemBits'(trial);
          q[19 - bit_cnt] <= 1'b1;
        end
        if (bit_cnt == 5'd19) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        bit_cnt <= bit_cnt + 5'd1;
      end
    end
  end

  assign qf = q;
  always_comb begin
    if (sat) begin
      quo = neg ? -tpl_pkg::QuotBits'(1 << 20) : tpl_pkg::QuotBits'(1 << 20);
    end else if (neg) begin
      quo = (rem == '0) ? -tpl_pkg::QuotBits'(qf)
                        : -(tpl_pkg::QuotBits'(qf) + tpl_pkg::QuotBits'(1));
    end else begin
      quo = tpl_pkg::QuotBits'(qf);
    end
  end

`ifndef ASSERT_OFF
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("divider done held");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("divider busy at done");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> bit_cnt <= 5'd19)
    else $error("divider count overrun");
`endif
endmodule

// ===== design/tpl_back.sv =====
// Back part: table store, scan sequencer, cross products, weight test and
// output register. Depends on tpl_pkg, tpl_ram and tpl_div.
module tpl_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  tpl_pkg::cmd_t q_cmd,
  input  logic [tpl_pkg::CntBits-1:0] triangle_count,
  input  logic [tpl_pkg::TolBits-1:0] edge_tolerance,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          found,
  output logic [tpl_pkg::IdxBits-1:0] triangle_index,
  output logic signed [tpl_pkg::WeightBits-1:0] weight_a,
  output logic signed [tpl_pkg::WeightBits-1:0] weight_b,
  output logic signed [tpl_pkg::WeightBits-1:0] weight_c
);
  localparam int CB = tpl_pkg::CoordBits;
  localparam int DB = tpl_pkg::DiffBits;
  localparam int XB = tpl_pkg::CrossBits;
  localparam int QB = tpl_pkg::QuotBits;
  localparam int IB = tpl_pkg::IdxBits;
  localparam int WB = tpl_pkg::WeightBits;

  tpl_pkg::state_t state, state_next;
  tpl_pkg::cmd_t   cur;
  logic [IB:0]     idx;
  logic [IB:0]     limit;
  logic [tpl_pkg::StoreBits-1:0] rd_data;
  logic ram_we;
  logic signed [CB-1:0] ta_x, ta_y, tb_x, tb_y, tc_x, tc_y;
  logic signed [DB-1:0] ux, uy, vx, vy, qx, qy;
  logic signed [XB-1:0] den_r, nb_r, nc_r;
  logic signed [XB-1:0] den_n, nb_n, nc_n;
  logic div_start, div_done_b, div_done_c;
  logic signed [QB-1:0] wb_q, wc_q;
  logic signed [QB:0]   wa_q;
  logic signed [QB:0]   ntol;
  logic pass;
  logic take;
  logic last;

  assign ram_we = (state == tpl_pkg::ST_IDLE) && q_valid &&
                  (q_cmd.mode == tpl_pkg::ModeWrite);

  tpl_ram #(.Width(tpl_pkg::StoreBits), .Depth(tpl_pkg::MaxTriangles)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_cmd.entry_index),
    .wdata ({q_cmd.ax, q_cmd.ay, q_cmd.bx, q_cmd.by, q_cmd.cx, q_cmd.cy}),
    .raddr (idx[IB-1:0]),
    .rdata (rd_data)
  );

  // The entry addressed in ST_READ is on rd_data during ST_CROSS.
  assign {ta_x, ta_y, tb_x, tb_y, tc_x, tc_y} = rd_data;
  assign ux = DB'(tb_x) - DB'(ta_x);
  assign uy = DB'(tb_y) - DB'(ta_y);
  assign vx = DB'(tc_x) - DB'(ta_x);
  assign vy = DB'(tc_y) - DB'(ta_y);
  assign qx = DB'(cur.px) - DB'(ta_x);
  assign qy = DB'(cur.py) - DB'(ta_y);

  assign limit = (triangle_count > tpl_pkg::CntBits'(tpl_pkg::MaxTriangles))
               ? (IB+1)'(tpl_pkg::MaxTriangles) : (IB+1)'(triangle_count);
  assign last  = (idx + (IB+1)'(1) >= limit);

  always_comb begin
    den_n = XB'(ux * vy) - XB'(uy * vx);
    nb_n  = XB'(qx * vy) - XB'(qy * vx);
    nc_n  = XB'(ux * qy) - XB'(uy * qx);
  end

  assign div_start = (state == tpl_pkg::ST_MUL) && (den_r != '0);

  tpl_div u_div_b (.clk(clk), .rst(rst), .start(div_start), .num(nb_r),
    .den(den_r), .done(div_done_b), .quo(wb_q));
  tpl_div u_div_c (.clk(clk), .rst(rst), .start(div_start), .num(nc_r),
    .den(den_r), .done(div_done_c), .quo(wc_q));

  assign wa_q = (QB+1)'(65536) - (QB+1)'(wb_q) - (QB+1)'(wc_q);
  assign ntol = -(QB+1)'(edge_tolerance);
  assign pass = (wa_q >= ntol) && ((QB+1)'(wb_q) >= ntol) && ((QB+1)'(wc_q) >= ntol);
  assign take = out_valid && out_ready;

  function automatic logic signed [WB-1:0] sat_w(input logic signed [QB:0] w);
    if (w > (QB+1)'(131071)) begin
      return WB'(131071);
    end else if (w < -(QB+1)'(131072)) begin
      return -WB'(131072);
    end
    return WB'(w);
  endfunction

  always_comb begin
    state_next = state;
    case (state)
      tpl_pkg::ST_IDLE: begin
        if (q_valid && q_cmd.mode == tpl_pkg::ModeQuery) begin
          state_next = (limit == '0) ? tpl_pkg::ST_OUT : tpl_pkg::ST_READ;
        end
      end
      tpl_pkg::ST_READ: state_next = tpl_pkg::ST_CROSS;
      tpl_pkg::ST_CROSS: state_next = tpl_pkg::ST_MUL;
      tpl_pkg::ST_MUL: begin
        if (den_r != '0) state_next = tpl_pkg::ST_DIV;
        else if (last)   state_next = tpl_pkg::ST_OUT;
        else             state_next = tpl_pkg::ST_READ;
      end
      tpl_pkg::ST_DIV: if (div_done_b) state_next = tpl_pkg::ST_TEST;
      tpl_pkg::ST_TEST: begin
        if (pass || last) state_next = tpl_pkg::ST_OUT;
        else              state_next = tpl_pkg::ST_READ;
      end
      // The result word stays put until the receiver takes it.
      tpl_pkg::ST_OUT: if (take) state_next = tpl_pkg::ST_IDLE;
      default: state_next = tpl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready = (state == tpl_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tpl_pkg::ST_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      state <= state_next;
      if (take) out_valid <= 1'b0;
      case (state)
        tpl_pkg::ST_IDLE: begin
          cur <= q_cmd;
          idx <= '0;
          found <= 1'b0;
          triangle_index <= '0;
          weight_a <= '0;
          weight_b <= '0;
          weight_c <= '0;
        end
        tpl_pkg::ST_CROSS: begin
          den_r <= den_n[XB-1] ? -den_n : den_n;
          nb_r  <= den_n[XB-1] ? -nb_n : nb_n;
          nc_r  <= den_n[XB-1] ? -nc_n : nc_n;
        end
        tpl_pkg::ST_MUL: begin
          if (den_r == '0) idx <= idx + (IB+1)'(1);
        end
        tpl_pkg::ST_TEST: begin
          if (pass) begin
            found <= 1'b1;
            triangle_index <= idx[IB-1:0];
            weight_a <= sat_w(wa_q);
            weight_b <= sat_w((QB+1)'(wb_q));
            weight_c <= sat_w((QB+1)'(wc_q));
          end else begin
            idx <= idx + (IB+1)'(1);
          end
        end
        tpl_pkg::ST_OUT: begin
          if (!out_valid) out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_div_pair: assert property (@(posedge clk) disable iff (rst)
    div_done_b == div_done_c)
    else $error("weight dividers out of step");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    q_ready |-> state == tpl_pkg::ST_IDLE)
    else $error("queue popped while busy");
  a_found_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> triangle_index == '0 && weight_a == '0)
    else $error("not-found result carries data");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= (IB+1)'(tpl_pkg::MaxTriangles))
    else $error("scan index overran table");
`endif
endmodule
